>>> rtl/core/fcb_pkg.sv
// ----------------------------------------------------------------------------
// FIR filter package
// Shared widths, command codes, rounding constants and the command and
// status groups that join the controller to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package fcb_pkg;

   // Field widths of the channels and the configuration register.
   localparam int DATA_W     = 16;
   localparam int COEF_IDX_W = 6;
   localparam int TAPS_REG_W = 7;
   localparam int PROD_W     = 2 * DATA_W;
   localparam int ACC_W      = 40;

   // Value of the tap count register after reset.
   localparam logic [TAPS_REG_W-1:0] TAPS_RESET = 7'd64;

   // Item command codes.
   localparam logic CMD_FILTER = 1'b0;
   localparam logic CMD_LOAD   = 1'b1;

   // Rounding from Q2.30 sums to Q1.15: add one half, then shift.
   localparam int RND_SHIFT = 15;
   localparam int RND_W     = ACC_W + 1 - RND_SHIFT;
   localparam logic signed [ACC_W:0]   ROUND_HALF = 41'sd16384;
   localparam logic signed [RND_W-1:0] RND_MAX    = 26'sd32767;
   localparam logic signed [RND_W-1:0] RND_MIN    = -26'sd32768;
   localparam logic signed [DATA_W-1:0] OUT_MAX   = 16'sh7fff;
   localparam logic signed [DATA_W-1:0] OUT_MIN   = 16'sh8000;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_coef;   // write one coefficient from the input item
      logic start;       // store the sample, advance the pointer, clear the sum
      logic issue;       // read one tap pair and step the walk
      logic finish;      // round, saturate and load the output register
   } fcb_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic walk_last;   // the tap being issued is the last one in use
      logic pipe_busy;   // products are still on their way to the sum
      logic out_free;    // the output register can take a new result
   } fcb_status_type;

endpackage : fcb_pkg

`default_nettype wire

>>> rtl/core/fcb_if.sv
// ----------------------------------------------------------------------------
// FIR filter channel interfaces
// Valid/ready channels for request items and response items.
// ----------------------------------------------------------------------------
`default_nettype none

// Request channel: a sample to filter or a coefficient to load.
interface fcb_req_if
   import fcb_pkg::*;
   ();
   logic                     valid;
   logic                     ready;
   logic                     cmd;
   logic [COEF_IDX_W-1:0]    coef_index;
   logic signed [DATA_W-1:0] value;

   modport source (output valid, output cmd, output coef_index, output value,
                   input ready);
   modport sink   (input valid, input cmd, input coef_index, input value,
                   output ready);
endinterface : fcb_req_if

// Response channel: one filtered sample per sample item.
interface fcb_rsp_if
   import fcb_pkg::*;
   ();
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] filtered_sample;
   logic                     saturated;

   modport source (output valid, output filtered_sample, output saturated,
                   input ready);
   modport sink   (input valid, input filtered_sample, input saturated,
                   output ready);
endinterface : fcb_rsp_if

`default_nettype wire

>>> rtl/core/fcb_ctrl.sv
// ----------------------------------------------------------------------------
// FIR filter controller
// Sequences one item at a time: accept, walk the taps, drain the
// multiply pipeline and hand the rounded result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module fcb_ctrl
   import fcb_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   input  wire logic           req_cmd,
   output logic                req_ready,
   input  wire fcb_status_type status,
   output fcb_cmd_type         cmd
);

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_WALK  = 3'b010,
      ST_DRAIN = 3'b100
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   // Items are taken only between sample computations.
   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   // Next state and command decode.
   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_cmd == CMD_LOAD) begin
                  cmd.load_coef = 1'b1;
               end else begin
                  cmd.start = 1'b1;
                  state_in  = ST_WALK;
               end
            end
         end
         ST_WALK: begin
            cmd.issue = 1'b1;
            if (status.walk_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!status.pipe_busy && status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule : fcb_ctrl

`default_nettype wire

>>> rtl/core/fcb_datapath.sv
// ----------------------------------------------------------------------------
// FIR filter datapath
// Delay line and coefficient memories, ring pointers, one shared
// multiply-accumulate pipeline, rounding and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module fcb_datapath
   import fcb_pkg::*;
#(
   parameter int TAPS = 64
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire fcb_cmd_type              cmd,
   output fcb_status_type                status,
   input  wire logic                     csr_wr_en,
   input  wire logic [TAPS_REG_W-1:0]    csr_wr_data,
   input  wire logic [COEF_IDX_W-1:0]    req_coef_index,
   input  wire logic signed [DATA_W-1:0] req_value,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic signed [DATA_W-1:0]      rsp_filtered_sample,
   output logic                          rsp_saturated
);

   localparam int PTR_W = (TAPS > 1) ? $clog2(TAPS) : 1;
   localparam int CNT_W = $clog2(TAPS + 1);
   localparam int SUM_W = CNT_W + 1;
   localparam int CMP_W = (CNT_W > TAPS_REG_W) ? CNT_W : TAPS_REG_W;
   localparam int CI_W  = (CNT_W > COEF_IDX_W) ? CNT_W : COEF_IDX_W;

   // Configuration and ring state.
   logic [TAPS_REG_W-1:0] taps_ff;
   logic [PTR_W-1:0]      ptr_ff;
   logic [PTR_W-1:0]      ptr_new;
   logic [CNT_W-1:0]      cnt_ff;
   logic [CNT_W-1:0]      eff_cnt;
   logic [CMP_W-1:0]      taps_wide;
   logic [SUM_W-1:0]      ptr_inc;
   logic [PTR_W-1:0]      idx_ff;
   logic [PTR_W-1:0]      tap_ff;

   // Memories with per-entry valid bits; an unwritten entry reads as zero.
   logic [DATA_W-1:0] smp_mem  [TAPS];
   logic [DATA_W-1:0] coef_mem [TAPS];
   logic [TAPS-1:0]   smp_vld_ff;
   logic [TAPS-1:0]   coef_vld_ff;
   logic [DATA_W-1:0] smp_rd_ff;
   logic [DATA_W-1:0] coef_rd_ff;
   logic              smp_rdv_ff;
   logic              coef_rdv_ff;
   logic              coef_we;
   logic [PTR_W-1:0]  coef_addr;

   // Multiply-accumulate pipeline.
   logic                     s1_vld_ff;
   logic                     s2_vld_ff;
   logic signed [DATA_W-1:0] smp_op;
   logic signed [DATA_W-1:0] coef_op;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [ACC_W-1:0]  acc_ff;

   // Rounding and output register.
   logic signed [ACC_W:0]       rnd_sum;
   logic signed [RND_W-1:0]     rnd_val;
   logic signed [DATA_W-1:0]    out_val;
   logic                        out_sat;
   logic                        rsp_valid_ff;
   logic signed [DATA_W-1:0]    rsp_sample_ff;
   logic                        rsp_sat_ff;

   // Tap count in use: zero acts as one, anything above the store as TAPS.
   always_comb begin
      taps_wide = CMP_W'(taps_ff);
      if (taps_wide == '0) begin
         eff_cnt = CNT_W'(1);
      end else if (taps_wide > CMP_W'(TAPS)) begin
         eff_cnt = CNT_W'(TAPS);
      end else begin
         eff_cnt = CNT_W'(taps_wide);
      end
   end

   // Next newest position, wrapping once it reaches or passes the count.
   always_comb begin
      ptr_inc = SUM_W'(ptr_ff) + SUM_W'(1);
      if (ptr_inc >= SUM_W'(eff_cnt)) begin
         ptr_new = '0;
      end else begin
         ptr_new = PTR_W'(ptr_inc);
      end
   end

   // Tap count register.
   always_ff @(posedge clock) begin
      if (reset) begin
         taps_ff <= TAPS_RESET;
      end else if (csr_wr_en) begin
         taps_ff <= csr_wr_data;
      end
   end

   // Ring pointer, backward walker and tap counter.
   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff <= '0;
      end else if (cmd.start) begin
         ptr_ff <= ptr_new;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         idx_ff <= ptr_new;
         tap_ff <= '0;
         cnt_ff <= eff_cnt;
      end else if (cmd.issue) begin
         tap_ff <= tap_ff + PTR_W'(1);
         if (idx_ff == '0) begin
            idx_ff <= PTR_W'(cnt_ff - CNT_W'(1));
         end else begin
            idx_ff <= idx_ff - PTR_W'(1);
         end
      end
   end

   // Coefficient loads beyond the store are dropped.
   assign coef_we   = cmd.load_coef && (CI_W'(req_coef_index) < CI_W'(TAPS));
   assign coef_addr = PTR_W'(req_coef_index);

   // Delay line memory.
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         smp_mem[ptr_new] <= req_value;
      end
      if (cmd.issue) begin
         smp_rd_ff <= smp_mem[idx_ff];
      end
   end

   // Coefficient memory.
   always_ff @(posedge clock) begin
      if (coef_we) begin
         coef_mem[coef_addr] <= req_value;
      end
      if (cmd.issue) begin
         coef_rd_ff <= coef_mem[tap_ff];
      end
   end

   // Valid bits, cleared together at reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         smp_vld_ff  <= '0;
         coef_vld_ff <= '0;
      end else begin
         if (cmd.start) begin
            smp_vld_ff[ptr_new] <= 1'b1;
         end
         if (coef_we) begin
            coef_vld_ff[coef_addr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.issue) begin
         smp_rdv_ff  <= smp_vld_ff[idx_ff];
         coef_rdv_ff <= coef_vld_ff[tap_ff];
      end
   end

   // Multiply stage: one product per cycle, registered before the sum.
   assign smp_op  = smp_rdv_ff  ? $signed(smp_rd_ff)  : '0;
   assign coef_op = coef_rdv_ff ? $signed(coef_rd_ff) : '0;

   always_ff @(posedge clock) begin
      if (s1_vld_ff) begin
         prod_ff <= smp_op * coef_op;
      end
   end

   // Pipeline occupancy.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= cmd.issue;
         s2_vld_ff <= s1_vld_ff;
      end
   end

   // Accumulator, wrapping at its width.
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         acc_ff <= '0;
      end else if (s2_vld_ff) begin
         acc_ff <= acc_ff + {{(ACC_W - PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
      end
   end

   // Round half up to Q1.15, then clamp to 16 bits.
   always_comb begin
      rnd_sum = {acc_ff[ACC_W-1], acc_ff} + ROUND_HALF;
      rnd_val = $signed(rnd_sum[ACC_W:RND_SHIFT]);
      if (rnd_val > RND_MAX) begin
         out_val = OUT_MAX;
         out_sat = 1'b1;
      end else if (rnd_val < RND_MIN) begin
         out_val = OUT_MIN;
         out_sat = 1'b1;
      end else begin
         out_val = DATA_W'(rnd_val);
         out_sat = 1'b0;
      end
   end

   // Output register: holds a result until the receiver takes it.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_sample_ff <= out_val;
         rsp_sat_ff    <= out_sat;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_filtered_sample = rsp_sample_ff;
   assign rsp_saturated       = rsp_sat_ff;

   // Status back to the controller.
   assign status.walk_last = (SUM_W'(tap_ff) + SUM_W'(1)) == SUM_W'(cnt_ff);
   assign status.pipe_busy = s1_vld_ff || s2_vld_ff;
   assign status.out_free  = !rsp_valid_ff || rsp_ready;

   // The result is taken only once every product has reached the sum.
   a_finish_drained: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> !s1_vld_ff && !s2_vld_ff)
      else $error("result formed while products were still in flight");

   // A new result never overwrites one the receiver has not taken.
   a_finish_free: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> (!rsp_valid_ff || rsp_ready))
      else $error("output register overwritten before it was taken");

   // The walk stays within the taps in use.
   a_issue_range: assert property (@(posedge clock) disable iff (reset)
      cmd.issue |-> (SUM_W'(tap_ff) < SUM_W'(cnt_ff)) &&
                    (SUM_W'(idx_ff) < SUM_W'(cnt_ff)))
      else $error("tap walk left the ring in use");

   // After a start, the newest position lies within the tap count in use.
   a_ptr_range: assert property (@(posedge clock) disable iff (reset)
      cmd.start |=> SUM_W'(ptr_ff) < SUM_W'(cnt_ff))
      else $error("newest pointer beyond the tap count");

endmodule : fcb_datapath

`default_nettype wire

>>> rtl/core/fir_filter_circular_buffer.sv
// ----------------------------------------------------------------------------
// FIR filter over a circular delay line
// Direct-form Q1.15 FIR filter with a run-time tap count and loadable
// coefficients, built as a controller and a multiply-accumulate datapath.
// ----------------------------------------------------------------------------
// Usage:
// Request items arrive on req_if. With cmd set to filter, the value is a new
// sample; the block stores it in the ring and returns one response item on
// rsp_if carrying the rounded, saturated filter output and a saturation flag.
// With cmd set to load, the value is written as the coefficient at
// coef_index (indices at or beyond TAPS are dropped) and no response follows.
// The tap count is written through csr_wr_en/csr_wr_data while idle.
// A load is written at the edge that accepts it. A sample is stored in the ring
// at the accepting edge; then one tap per cycle goes through the single shared
// multiplier, the read and multiply stages drain and the sum is rounded into
// the output register. No new item is taken while a sample is being filtered.
// Reset clears the delay line, the coefficients and the ring pointer at once
// and sets the tap count to 64. A stalled receiver holds the response in the
// output register; the next request may still be accepted, and only its
// rounding step waits until the held response has been taken.
// ----------------------------------------------------------------------------
`default_nettype none

module fir_filter_circular_buffer
   import fcb_pkg::*;
#(
   parameter int TAPS = 64
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_wr_en,
   input  wire logic [TAPS_REG_W-1:0] csr_wr_data,
   fcb_req_if.sink                    req_if,
   fcb_rsp_if.source                  rsp_if
);

   fcb_cmd_type    cmd;
   fcb_status_type status;
   logic           req_ready;

   assign req_if.ready = req_ready;

   // Item sequencing.
   fcb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_cmd   (req_if.cmd),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Storage, arithmetic and output register.
   fcb_datapath #(
      .TAPS (TAPS)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .req_coef_index      (req_if.coef_index),
      .req_value           (req_if.value),
      .rsp_valid           (rsp_if.valid),
      .rsp_ready           (rsp_if.ready),
      .rsp_filtered_sample (rsp_if.filtered_sample),
      .rsp_saturated       (rsp_if.saturated)
   );

endmodule : fir_filter_circular_buffer

`default_nettype wire

>>> bench/tb_fir_filter_circular_buffer.sv
// ----------------------------------------------------------------------------
// FIR filter over a circular delay line: testbench
// Drives sample and coefficient items into the filter under random stalls
// on both channels, across a range of tap count settings. An own model of
// the ring, coefficients, accumulation, rounding and saturation predicts
// every filtered sample, and each response item is checked field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_fir_filter_circular_buffer;
   import fcb_pkg::*;

   localparam int RING_DEPTH     = 64;
   localparam int ITEM_TARGET    = 450;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int SETTLE_CYCLES  = 4;
   localparam int END_CYCLES     = 80;
   localparam int TAP_PLAN [12]  = '{64, 3, 1, 17, 0, 100, 8, 64, 5, 2, 33, 127};

   // Tracks the filter state and holds the filtered samples still due.
   class fir_scoreboard;
      typedef struct {
         logic signed [DATA_W-1:0] sample;
         logic                     sat;
      } filter_out_type;

      logic signed [DATA_W-1:0] ring [RING_DEPTH];
      logic signed [DATA_W-1:0] coefs [RING_DEPTH];
      int unsigned              newest;
      logic [TAPS_REG_W-1:0]    taps;
      filter_out_type           expected_q [$];
      int                       mismatches;
      int                       samples;
      int                       loads;
      int                       checked;
      int                       clamped;

      function new();
         foreach (ring[i]) begin
            ring[i]  = '0;
            coefs[i] = '0;
         end
         newest     = 0;
         taps       = TAPS_RESET;
         mismatches = 0;
         samples    = 0;
         loads      = 0;
         checked    = 0;
         clamped    = 0;
      endfunction

      function void set_taps(logic [TAPS_REG_W-1:0] value);
         taps = value;
      endfunction

      // A count of zero behaves as one, anything beyond the ring as the ring.
      function int unsigned live_taps();
         if (taps == 0) return 1;
         if (taps > RING_DEPTH) return RING_DEPTH;
         return 32'(taps);
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      // Applies one accepted request item and queues the filtered sample.
      function void note_item(logic cmd, logic [COEF_IDX_W-1:0] idx,
                              logic signed [DATA_W-1:0] value);
         int unsigned              span;
         int unsigned              pos;
         logic signed [ACC_W-1:0]  acc;
         longint                   rounded;
         filter_out_type           res;
         if (cmd == CMD_LOAD) begin
            coefs[idx] = value;
            loads++;
            return;
         end
         span   = live_taps();
         newest = newest + 1;
         if (newest >= span) newest = 0;
         ring[newest] = value;
         // Walk backwards from the newest sample, wrapping at the tap count.
         acc = '0;
         pos = newest;
         for (int i = 0; i < span; i++) begin
            acc = acc + coefs[i] * ring[pos];
            pos = (pos == 0) ? span - 1 : pos - 1;
         end
         // Round halves upwards, then clamp to the Q1.15 range.
         rounded = (longint'(acc) + 16384) >>> RND_SHIFT;
         res.sat = 1'b0;
         if (rounded > 32767) begin
            res.sample = OUT_MAX;
            res.sat    = 1'b1;
         end else if (rounded < -32768) begin
            res.sample = OUT_MIN;
            res.sat    = 1'b1;
         end else begin
            res.sample = rounded[DATA_W-1:0];
         end
         expected_q.push_back(res);
         samples++;
      endfunction

      task report(string what);
         $display("[%0t] mismatch: %s", $time, what);
         mismatches++;
      endtask

      // Compares one response item with the oldest expected filtered sample.
      task check_result(logic signed [DATA_W-1:0] got_sample, logic got_sat);
         filter_out_type want;
         if (expected_q.size() == 0) begin
            report($sformatf("response %0d / sat %0b with nothing expected",
                             got_sample, got_sat));
            return;
         end
         want = expected_q.pop_front();
         checked++;
         if (want.sat) clamped++;
         if (got_sample !== want.sample)
            report($sformatf("filtered_sample %0d, expected %0d",
                             got_sample, want.sample));
         if (got_sat !== want.sat)
            report($sformatf("saturated %0b, expected %0b", got_sat, want.sat));
      endtask

      task flush_check();
         while (expected_q.size() != 0) begin
            report($sformatf("filtered sample %0d never arrived",
                             expected_q[0].sample));
            void'(expected_q.pop_front());
         end
      endtask
   endclass

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  csr_wr_en   = 1'b0;
   logic [TAPS_REG_W-1:0] csr_wr_data = '0;
   bit                    tx_calm     = 1'b0;
   bit                    rx_calm     = 1'b0;
   int                    items_sent  = 0;
   int                    settings    = 0;
   int                    quiet_cycles = 0;
   fir_scoreboard         board       = new();

   fcb_req_if req_bus ();
   fcb_rsp_if rsp_bus ();

   fir_filter_circular_buffer i_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_if      (req_bus),
      .rsp_if      (rsp_bus)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Mostly short gaps, now and then a long one; none at all when calm.
   function automatic int pick_gap(bit calm);
      int roll;
      roll = $urandom_range(0, 99);
      if (calm || roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Q1.15 values with the extremes and small magnitudes favoured.
   function automatic logic signed [DATA_W-1:0] pick_value();
      case ($urandom_range(0, 19))
         0: return OUT_MAX;
         1: return OUT_MIN;
         2: return '0;
         3: return 16'sh0001;
         4: return 16'shffff;
         default: return DATA_W'($urandom_range(0, 65535));
      endcase
   endfunction

   // Offers one request item after a random gap and waits for its acceptance.
   task automatic send_item(logic cmd, logic [COEF_IDX_W-1:0] idx,
                            logic signed [DATA_W-1:0] value);
      int gap;
      gap = pick_gap(tx_calm);
      if (gap > 0) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_bus.valid      <= 1'b1;
      req_bus.cmd        <= cmd;
      req_bus.coef_index <= idx;
      req_bus.value      <= value;
      do @(posedge clock); while (!req_bus.ready);
      board.note_item(cmd, idx, value);
      items_sent++;
   endtask

   // Holds the sender off until every filtered sample due has come back.
   task automatic wait_for_outputs();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_tap_count(logic [TAPS_REG_W-1:0] value);
      wait_for_outputs();
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      board.set_taps(value);
      settings++;
   endtask

   // Response side: random stalls on ready.
   initial begin : rsp_stall
      int hold;
      hold          = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold > 0) begin
            rsp_bus.ready <= 1'b0;
            hold--;
         end else begin
            rsp_bus.ready <= 1'b1;
            hold = pick_gap(rx_calm);
         end
      end
   end

   // Every accepted response item is checked at the edge that takes it.
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         board.check_result(rsp_bus.filtered_sample, rsp_bus.saturated);
   end

   // Ends the run if neither channel moves an item for too long.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin : stimulus
      int                    phase;
      int                    span;
      logic [TAPS_REG_W-1:0] taps;
      logic [COEF_IDX_W-1:0] idx;
      req_bus.valid      = 1'b0;
      req_bus.cmd        = CMD_FILTER;
      req_bus.coef_index = '0;
      req_bus.value      = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset tap count with cleared coefficients, then the end taps loaded.
      send_item(CMD_FILTER, 6'd0, OUT_MAX);
      send_item(CMD_FILTER, 6'd63, OUT_MIN);
      send_item(CMD_LOAD, 6'd63, OUT_MIN);
      send_item(CMD_LOAD, 6'd0, OUT_MAX);
      send_item(CMD_FILTER, 6'd0, '0);
      send_item(CMD_FILTER, 6'd0, 16'sd12345);
      send_item(CMD_FILTER, 6'd0, 16'shffff);

      // Lowering the count below the pointer forces a wrap on the next sample.
      // Two taps of full negative scale, then of full positive scale, drive the sum past both rails.
      write_tap_count(7'd2);
      send_item(CMD_LOAD, 6'd0, OUT_MIN);
      send_item(CMD_LOAD, 6'd1, OUT_MIN);
      send_item(CMD_FILTER, 6'd0, OUT_MIN);
      send_item(CMD_FILTER, 6'd0, OUT_MIN);
      send_item(CMD_FILTER, 6'd0, OUT_MAX);
      send_item(CMD_LOAD, 6'd0, OUT_MAX);
      send_item(CMD_LOAD, 6'd1, OUT_MAX);
      send_item(CMD_FILTER, 6'd0, OUT_MIN);
      send_item(CMD_FILTER, 6'd0, OUT_MIN);

      // One tap with the smallest coefficient exercises the rounding of halves.
      write_tap_count(7'd1);
      send_item(CMD_LOAD, 6'd0, 16'sh0001);
      send_item(CMD_FILTER, 6'd0, 16'sd16384);
      send_item(CMD_FILTER, 6'd0, -16'sd16384);
      send_item(CMD_FILTER, 6'd0, 16'sd16383);

      // A count of zero and a count above the ring are both clipped.
      write_tap_count(7'd0);
      send_item(CMD_FILTER, 6'd0, 16'sd16384);
      write_tap_count(7'd127);
      send_item(CMD_FILTER, 6'd0, 16'sd100);

      // Random phases, each under its own tap count and idling pattern.
      phase = 0;
      while (items_sent < ITEM_TARGET) begin
         if (phase < $size(TAP_PLAN))
            taps = TAPS_REG_W'(TAP_PLAN[phase]);
         else if ($urandom_range(0, 3) == 0)
            taps = TAPS_REG_W'($urandom_range(0, 127));
         else
            taps = TAPS_REG_W'($urandom_range(1, 12));
         write_tap_count(taps);
         span    = (taps == 0) ? 1 : (taps > RING_DEPTH) ? RING_DEPTH : int'(taps);
         tx_calm = ($urandom_range(0, 3) == 0);
         rx_calm = ($urandom_range(0, 3) == 0);
         repeat ($urandom_range(20, 45)) begin
            if ($urandom_range(0, 9) < 3) begin
               if ($urandom_range(0, 1) == 1)
                  idx = COEF_IDX_W'($urandom_range(0, span - 1));
               else
                  idx = COEF_IDX_W'($urandom_range(0, RING_DEPTH - 1));
               send_item(CMD_LOAD, idx, pick_value());
            end else begin
               idx = COEF_IDX_W'($urandom_range(0, RING_DEPTH - 1));
               send_item(CMD_FILTER, idx, pick_value());
            end
            if ($urandom_range(0, 49) == 0) wait_for_outputs();
         end
         phase++;
      end

      wait_for_outputs();
      repeat (END_CYCLES) @(posedge clock);
      board.flush_check();
      $display("Filtered %0d samples and loaded %0d coefficients under %0d tap counts.",
               board.samples, board.loads, settings);
      $display("%0d responses checked, %0d of them clamped at a rail.",
               board.checked, board.clamped);
      if (board.mismatches == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule : tb_fir_filter_circular_buffer

`default_nettype wire

>>> fir_filter_circular_buffer.f
rtl/core/fcb_pkg.sv
rtl/core/fcb_if.sv
rtl/core/fcb_ctrl.sv
rtl/core/fcb_datapath.sv
rtl/core/fir_filter_circular_buffer.sv
bench/tb_fir_filter_circular_buffer.sv
